// ----- design/dual_contact_key_velocity_top_defines.svh -----
// Assertion macros shared by the design files.
`ifndef DUAL_CONTACT_KEY_VELOCITY_TOP_DEFINES_SVH
`define DUAL_CONTACT_KEY_VELOCITY_TOP_DEFINES_SVH

// Implication checked on every clock edge outside reset.
`define DCKV_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define DCKV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dckv_pkg.sv -----
`default_nettype none
package dckv_pkg;
  localparam int NUM_KEYS = 88;
  localparam int KEY_W = 7;
  localparam int TIME_W = 32;
  localparam int CFG_W = 20;
  localparam int CFG_IDX_W = 3;
  localparam int VEL_W = 16;
  localparam int DIV_W = 56;

  localparam logic [CFG_IDX_W-1:0] REG_NOTE_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ON_FAST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ON_SLOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_FAST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_SLOW = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_BIAS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 3'd6;

  localparam logic [1:0] POS_UP = 2'd0;
  localparam logic [1:0] POS_GOING_DOWN = 2'd1;
  localparam logic [1:0] POS_DOWN = 2'd2;
  localparam logic [1:0] POS_GOING_UP = 2'd3;

  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_NOTE_ON = 2'd1;
  localparam logic [1:0] EV_NOTE_OFF = 2'd2;

  typedef struct packed {
    logic [1:0] position;
    logic [TIME_W-1:0] travel_start;
    logic [TIME_W-1:0] upper_stamp;
    logic [TIME_W-1:0] lower_stamp;
    logic upper_lock;
    logic lower_lock;
    logic upper_seen;
    logic lower_seen;
  } key_rec_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [DIV_W-1:0] quot;
  } div_stat_t;
endpackage
`default_nettype wire

// ----- design/dckv_divider.sv -----
`default_nettype none
module dckv_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire dckv_pkg::div_req_t req,
  output dckv_pkg::div_stat_t stat
);
  import dckv_pkg::*;
  `include "dual_contact_key_velocity_top_defines.svh"

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] quot;
  logic [DIV_W-1:0] den;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic done;
  logic [DIV_W:0] trial;
  logic [DIV_W-1:0] rem_sh;

  // one quotient bit a cycle, restoring
  always_comb begin
    rem_sh = {rem[DIV_W-2:0], quot[DIV_W-1]};
    trial = {rem[DIV_W-1], rem_sh} - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(DIV_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= '0;
      quot <= req.num;
      den <= req.den;
    end else if (busy) begin
      if (!trial[DIV_W]) begin
        rem <= trial[DIV_W-1:0];
        quot <= {quot[DIV_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quot <= {quot[DIV_W-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign stat.quot = quot;

  `DCKV_ASSERT_NEXT(a_div_done_once, done, !done, "divider done held two cycles")
  `DCKV_ASSERT_IMP(a_div_no_restart, busy, !req.start, "divider restarted while busy")
  `DCKV_ASSERT_IMP(a_div_done_idle, done, !busy, "divider done while busy")
endmodule
`default_nettype wire

// ----- design/dual_contact_key_velocity_top.sv -----
`default_nettype none
// Channel   | direction | handshake          | payload
// ----------+-----------+--------------------+--------------------------------------
// in        | in        | in_valid/in_stall  | key_index, upper_contact, lower_contact, now_us
// out       | out       | out_valid/out_stall| event_kind, note_number, velocity
// cfg       | in        | cfg_we             | cfg_index, cfg_data
//
// A request passes S_IDLE, S_READ, S_RULE and S_OUT; one that raises an event also passes
// S_DIV, where the 56-step shift/subtract divider runs unless the divisor is zero.
// A new request is taken once the result register is free again.
// Reset clears the per-key valid bits; a key not yet written reads as all zero.
// Stall on the output holds the result; stall on the input is low only when idle.
module dual_contact_key_velocity_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [dckv_pkg::KEY_W-1:0] key_index,
  input  wire logic upper_contact,
  input  wire logic lower_contact,
  input  wire logic [dckv_pkg::TIME_W-1:0] now_us,
  output logic out_valid,
  input  wire logic out_stall,
  output logic [1:0] event_kind,
  output logic [6:0] note_number,
  output logic [dckv_pkg::VEL_W-1:0] velocity,
  input  wire logic cfg_we,
  input  wire logic [dckv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dckv_pkg::CFG_W-1:0] cfg_data
);
  import dckv_pkg::*;
  `include "dual_contact_key_velocity_top_defines.svh"

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_RULE = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [6:0] key_note_offset;
  logic [CFG_W-1:0] on_fast, on_slow, off_fast, off_slow, settle_time;
  logic [15:0] curve_bias;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_note_offset <= 7'd21;
      on_fast <= 20'd3000;
      on_slow <= 20'd120000;
      off_fast <= 20'd4000;
      off_slow <= 20'd80000;
      curve_bias <= 16'd6554;
      settle_time <= 20'd5000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NOTE_OFFSET: key_note_offset <= cfg_data[6:0];
        REG_ON_FAST: on_fast <= cfg_data;
        REG_ON_SLOW: on_slow <= cfg_data;
        REG_OFF_FAST: off_fast <= cfg_data;
        REG_OFF_SLOW: off_slow <= cfg_data;
        REG_CURVE_BIAS: curve_bias <= cfg_data[15:0];
        REG_SETTLE: settle_time <= cfg_data;
        default: ;
      endcase
    end
  end

  // per-key state memory with valid bits
  key_rec_t mem [NUM_KEYS];
  logic [NUM_KEYS-1:0] kvalid;
  key_rec_t rd_data, rec;
  logic rd_valid;
  logic mem_we;
  key_rec_t wr_data;

  // latched request
  logic [KEY_W-1:0] k;
  logic uc, lc;
  logic [TIME_W-1:0] now;
  logic in_range;

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      k <= key_index;
      uc <= upper_contact;
      lc <= lower_contact;
      now <= now_us;
    end
  end
  assign in_range = k < KEY_W'(NUM_KEYS);

  always_ff @(posedge clk) begin
    if (state == S_READ && in_range) rd_data <= mem[k[6:0]];
    if (mem_we) mem[k[6:0]] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) kvalid <= '0;
    else if (mem_we) kvalid[k[6:0]] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) rd_valid <= in_range && kvalid[k[6:0]];
  end

  assign rec = rd_valid ? rd_data : '0;

  // rule evaluation, in order; travel time taken from the start as it stands
  // when the event fires (a release edge may restart it in the same step)
  key_rec_t s;
  logic [1:0] kind;
  logic [TIME_W-1:0] elapsed;
  always_comb begin
    s = rec;
    kind = EV_NONE;
    elapsed = '0;
    if (lc && !s.lower_seen && s.position == POS_GOING_DOWN && !s.lower_lock) begin
      s.lower_seen = 1'b1; s.lower_stamp = now; s.lower_lock = 1'b1;
      s.position = POS_DOWN; kind = EV_NOTE_ON;
      elapsed = now - s.travel_start;
    end
    if (!lc && s.lower_seen && s.position == POS_DOWN && !s.lower_lock) begin
      s.lower_seen = 1'b0; s.lower_stamp = now; s.lower_lock = 1'b1;
      s.position = POS_GOING_UP; s.travel_start = now;
    end
    if (uc && !s.upper_seen && s.position == POS_UP && !s.upper_lock) begin
      s.upper_seen = 1'b1; s.upper_stamp = now; s.upper_lock = 1'b1;
      s.position = POS_GOING_DOWN; s.travel_start = now;
    end
    if (!uc && s.upper_seen && s.position == POS_GOING_UP && !s.upper_lock) begin
      s.upper_seen = 1'b0; s.upper_stamp = now; s.upper_lock = 1'b1;
      s.position = POS_UP; kind = EV_NOTE_OFF;
      elapsed = now - s.travel_start;
    end
    if (s.upper_lock && (now - s.upper_stamp) >= TIME_W'(settle_time)) s.upper_lock = 1'b0;
    if (s.lower_lock && (now - s.lower_stamp) >= TIME_W'(settle_time)) s.lower_lock = 1'b0;
    if (!uc && s.position == POS_GOING_DOWN && !s.upper_lock) begin
      s.upper_seen = 1'b0; s.position = POS_UP;
    end
    if (lc && s.position == POS_GOING_UP && !s.lower_lock) begin
      s.lower_seen = 1'b1; s.position = POS_DOWN;
    end
  end

  // travel parts: only the clamp and one subtract each; a=1, r=t=0 when slow is not above fast
  logic [CFG_W-1:0] fast, slow;
  logic degenerate;
  logic [TIME_W-1:0] e_cl;
  logic [CFG_W-1:0] t_part, r_part, a_part;
  always_comb begin
    fast = (kind == EV_NOTE_ON) ? on_fast : off_fast;
    slow = (kind == EV_NOTE_ON) ? on_slow : off_slow;
    degenerate = slow <= fast;
    e_cl = elapsed;
    if (e_cl < TIME_W'(fast)) e_cl = TIME_W'(fast);
    if (e_cl > TIME_W'(slow)) e_cl = TIME_W'(slow);
    r_part = slow - fast;
    t_part = e_cl[CFG_W-1:0] - fast;
    a_part = r_part - t_part;
    if (degenerate) begin
      r_part = '0; t_part = '0; a_part = 20'd1;
    end
  end

  // registered operands, then the numerator multiply and the denominator add in turn
  logic [1:0] kind_r;
  logic [CFG_W-1:0] a_r, t_r, r_r;
  logic [35:0] num_r;
  logic [36:0] den_r;
  logic [1:0] prep;
  div_req_t dreq;
  div_stat_t dstat;
  logic zero_den;

  dckv_divider u_div (.clk(clk), .rst(rst), .req(dreq), .stat(dstat));

  always_ff @(posedge clk) begin
    if (state == S_RULE) begin
      kind_r <= kind;
      a_r <= a_part;
      t_r <= t_part;
      r_r <= r_part;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) prep <= '0;
    else if (state == S_DIV && !dstat.busy && !dstat.done) prep <= prep + 1'b1;
    else if (state != S_DIV) prep <= '0;
  end

  always_ff @(posedge clk) begin
    if (state == S_DIV && prep == 2'd0) begin
      num_r <= (kind_r == EV_NOTE_ON) ? 36'(a_r) * 36'(curve_bias) : 36'(a_r);
    end
    if (state == S_DIV && prep == 2'd1) begin
      den_r <= (kind_r == EV_NOTE_ON) ? (37'(num_r) + {1'b0, t_r, 16'd0})
                                      : 37'(r_r);
    end
  end

  assign zero_den = den_r == '0;
  always_comb begin
    dreq.start = state == S_DIV && prep == 2'd2 && !zero_den;
    dreq.num = (DIV_W'(num_r) << 15) + DIV_W'(den_r >> 1);
    dreq.den = DIV_W'(den_r);
  end

  // result register
  logic [1:0] ev_q;
  logic [6:0] note_q;
  logic [VEL_W-1:0] vel_q;
  logic [7:0] note_sum;
  assign note_sum = {1'b0, k} + {1'b0, key_note_offset};

  always_ff @(posedge clk) begin
    if (state == S_RULE) begin
      ev_q <= kind;
      note_q <= (kind == EV_NONE) ? 7'd0 : (note_sum > 8'd127 ? 7'd127 : note_sum[6:0]);
      vel_q <= '0;
    end else if (state == S_DIV && prep == 2'd2 && zero_den) begin
      vel_q <= (kind_r == EV_NOTE_ON) ? 16'd0 : 16'd32768;
    end else if (dstat.done) begin
      vel_q <= dstat.quot[VEL_W-1:0];
    end
  end

  assign mem_we = state == S_RULE && in_range;
  assign wr_data = s;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_READ;
      S_READ: state_next = S_RULE;
      S_RULE: state_next = (in_range && kind != EV_NONE) ? S_DIV : S_OUT;
      S_DIV: if (dstat.done || (prep == 2'd2 && zero_den)) state_next = S_OUT;
      S_OUT: if (!out_stall) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  logic ev_gate;
  assign ev_gate = in_range;
  assign in_stall = state != S_IDLE;
  assign out_valid = state == S_OUT;
  assign event_kind = ev_gate ? ev_q : EV_NONE;
  assign note_number = ev_gate ? note_q : 7'd0;
  assign velocity = ev_gate ? vel_q : '0;

  `DCKV_ASSERT_IMP(a_out_idle_busy, out_valid, in_stall, "result shown while taking requests")
  `DCKV_ASSERT_NEXT(a_in_starts, !in_stall && in_valid, state == S_READ, "request not started")
  `DCKV_ASSERT_IMP(a_none_zero_vel, out_valid && event_kind == EV_NONE, velocity == '0,
                   "velocity on empty result")
endmodule
`default_nettype wire

// ----- tb/dual_contact_key_velocity_top_test.sv -----
`timescale 1ns / 1ps
module dual_contact_key_velocity_top_test;
  import dckv_pkg::*;

  // One scanned key sample, as sent on the input channel.
  typedef struct {
    logic [KEY_W-1:0] key;
    logic upper;
    logic lower;
    logic [TIME_W-1:0] stamp;
  } scan_t;

  // One note event, as seen on the output channel.
  typedef struct {
    logic [1:0] kind;
    logic [6:0] note;
    logic [VEL_W-1:0] vel;
  } note_event_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [KEY_W-1:0] key_index = '0;
  logic upper_contact = 1'b0;
  logic lower_contact = 1'b0;
  logic [TIME_W-1:0] now_us = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] event_kind;
  logic [6:0] note_number;
  logic [VEL_W-1:0] velocity;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  dual_contact_key_velocity_top dut (.*);

  // Predictor copy of the registers.
  logic [6:0] note_offset;
  logic [19:0] on_fast, on_slow, off_fast, off_slow, settle_us;
  logic [15:0] bias;

  // Predictor copy of the per-key state.
  logic [1:0] key_pos[NUM_KEYS];
  logic [TIME_W-1:0] travel_t0[NUM_KEYS];
  logic [TIME_W-1:0] upper_t[NUM_KEYS];
  logic [TIME_W-1:0] lower_t[NUM_KEYS];
  logic upper_locked[NUM_KEYS];
  logic lower_locked[NUM_KEYS];
  logic upper_closed[NUM_KEYS];
  logic lower_closed[NUM_KEYS];

  scan_t pending_scans[$];
  note_event_t awaited_events[$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  logic [TIME_W-1:0] clock_us;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("dual_contact_key_velocity_top_test failed");
    $finish;
  end

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Clamps travel time and splits it into remaining (a), spent (t) and range (r) parts; a=1 if slow <= fast.
  function automatic void split_travel(input logic [31:0] e, input logic [19:0] fast,
                                       input logic [19:0] slow, output logic [63:0] a,
                                       output logic [63:0] t, output logic [63:0] r);
    logic [31:0] c;
    if (slow <= fast) begin
      r = 0; a = 1; t = 0;
    end else begin
      c = e;
      if (c < fast) c = fast;
      if (c > slow) c = slow;
      r = slow - fast;
      t = c - fast;
      a = r - t;
    end
  endfunction

  function automatic logic [15:0] press_velocity(input logic [31:0] e);
    logic [63:0] a, t, r, num, den;
    split_travel(e, on_fast, on_slow, a, t, r);
    num = a * bias;
    den = num + t * 64'd65536;
    if (den == 0) return 16'd0;
    return 16'((num * 64'd32768 + den / 2) / den);
  endfunction

  function automatic logic [15:0] release_velocity(input logic [31:0] e);
    logic [63:0] a, t, r;
    split_travel(e, off_fast, off_slow, a, t, r);
    if (r == 0) return 16'd32768;
    return 16'((a * 64'd32768 + r / 2) / r);
  endfunction

  // Applies one sample to the key state and gives the event it raises.
  function automatic note_event_t key_scan_predict(input scan_t s);
    note_event_t ev;
    int k;
    logic [7:0] n;
    ev = '{EV_NONE, 7'd0, 16'd0};
    k = s.key;
    if (k >= NUM_KEYS) return ev;
    if (s.lower && !lower_closed[k] && key_pos[k] == POS_GOING_DOWN && !lower_locked[k]) begin
      lower_closed[k] = 1; lower_t[k] = s.stamp; lower_locked[k] = 1;
      key_pos[k] = POS_DOWN;
      ev.kind = EV_NOTE_ON;
      ev.vel = press_velocity(s.stamp - travel_t0[k]);
    end
    if (!s.lower && lower_closed[k] && key_pos[k] == POS_DOWN && !lower_locked[k]) begin
      lower_closed[k] = 0; lower_t[k] = s.stamp; lower_locked[k] = 1;
      key_pos[k] = POS_GOING_UP; travel_t0[k] = s.stamp;
    end
    if (s.upper && !upper_closed[k] && key_pos[k] == POS_UP && !upper_locked[k]) begin
      upper_closed[k] = 1; upper_t[k] = s.stamp; upper_locked[k] = 1;
      key_pos[k] = POS_GOING_DOWN; travel_t0[k] = s.stamp;
    end
    if (!s.upper && upper_closed[k] && key_pos[k] == POS_GOING_UP && !upper_locked[k]) begin
      upper_closed[k] = 0; upper_t[k] = s.stamp; upper_locked[k] = 1;
      key_pos[k] = POS_UP;
      ev.kind = EV_NOTE_OFF;
      ev.vel = release_velocity(s.stamp - travel_t0[k]);
    end
    // lockouts expire with modular elapsed time
    if (upper_locked[k] && (s.stamp - upper_t[k]) >= {12'd0, settle_us}) upper_locked[k] = 0;
    if (lower_locked[k] && (s.stamp - lower_t[k]) >= {12'd0, settle_us}) lower_locked[k] = 0;
    // bounce-back: contact fell back before the travel completed
    if (!s.upper && key_pos[k] == POS_GOING_DOWN && !upper_locked[k]) begin
      upper_closed[k] = 0; key_pos[k] = POS_UP;
    end
    if (s.lower && key_pos[k] == POS_GOING_UP && !lower_locked[k]) begin
      lower_closed[k] = 1; key_pos[k] = POS_DOWN;
    end
    if (ev.kind != EV_NONE) begin
      n = 8'(k) + {1'b0, note_offset};
      ev.note = (n > 127) ? 7'd127 : n[6:0];
    end
    return ev;
  endfunction

  // Driver: predicts on acceptance, then offers the next request or idles.
  always @(posedge clk) begin
    scan_t s;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        awaited_events.push_back(key_scan_predict('{key_index, upper_contact,
                                                    lower_contact, now_us}));
      end
      if (!in_valid || !in_stall) begin
        if (pending_scans.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          s = pending_scans.pop_front();
          in_valid <= 1'b1;
          key_index <= s.key;
          upper_contact <= s.upper;
          lower_contact <= s.lower;
          now_us <= s.stamp;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each taken result against the oldest expectation.
  always @(posedge clk) begin
    note_event_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_events.size() == 0) begin
          flag_mismatch("unexpected result, kind", event_kind, 0);
        end else begin
          want = awaited_events.pop_front();
          if (event_kind !== want.kind) flag_mismatch("event_kind", event_kind, want.kind);
          if (note_number !== want.note) flag_mismatch("note_number", note_number, want.note);
          if (velocity !== want.vel) flag_mismatch("velocity", velocity, want.vel);
        end
      end
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Idling pattern rotates through none, sender, receiver, both.
  always @(posedge clk) begin
    int cyc;
    cyc = int'($realtime / 8);
    case ((cyc / 600) % 4)
      0: begin sender_idle_pct <= 0; receiver_stall_pct <= 0; end
      1: begin sender_idle_pct <= 46; receiver_stall_pct <= 0; end
      2: begin sender_idle_pct <= 0; receiver_stall_pct <= 46; end
      default: begin sender_idle_pct <= 14; receiver_stall_pct <= 14; end
    endcase
  end

  task automatic set_predicted_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] v);
    case (idx)
      REG_NOTE_OFFSET: note_offset = v[6:0];
      REG_ON_FAST: on_fast = v;
      REG_ON_SLOW: on_slow = v;
      REG_OFF_FAST: off_fast = v;
      REG_OFF_SLOW: off_slow = v;
      REG_CURVE_BIAS: bias = v[15:0];
      REG_SETTLE: settle_us = v;
      default: ;
    endcase
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    set_predicted_reg(idx, v);
  endtask

  task automatic write_all(input logic [6:0] ofs, input logic [19:0] onf, input logic [19:0] ons,
                           input logic [19:0] offf, input logic [19:0] offs,
                           input logic [15:0] b, input logic [19:0] st);
    write_reg(REG_NOTE_OFFSET, 20'(ofs));
    write_reg(REG_ON_FAST, onf);
    write_reg(REG_ON_SLOW, ons);
    write_reg(REG_OFF_FAST, offf);
    write_reg(REG_OFF_SLOW, offs);
    write_reg(REG_CURVE_BIAS, 20'(b));
    write_reg(REG_SETTLE, st);
    write_reg(3'd7, 20'hFFFFF);  // unmapped index, must be ignored
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic scan(input int k, input bit u, input bit l, input int unsigned dt);
    clock_us += dt;
    pending_scans.push_back('{k[KEY_W-1:0], u, l, clock_us});
  endtask

  // A full press and release of one key, with optional contact bounce.
  task automatic keystroke(input int k, input int unsigned press_us, input int unsigned rel_us);
    scan(k, 1'b1, 1'b0, $urandom_range(20000));
    if ($urandom_range(3) == 0) begin
      scan(k, 1'b0, 1'b0, $urandom_range(8000));
      scan(k, 1'b1, 1'b0, $urandom_range(8000));
    end
    scan(k, 1'b1, 1'b1, press_us);
    scan(k, 1'b1, 1'b1, $urandom_range(30000));
    scan(k, 1'b1, 1'b0, $urandom_range(20000));
    if ($urandom_range(3) == 0) scan(k, 1'b1, 1'b1, $urandom_range(8000));
    scan(k, 1'b0, 1'b0, rel_us);
  endtask

  task automatic random_phase(input int n);
    int target;
    target = pending_scans.size() + n;
    while (pending_scans.size() < target) begin
      if ($urandom_range(9) < 7) begin
        keystroke($urandom_range(NUM_KEYS - 1), $urandom_range(160000),
                  $urandom_range(100000));
      end else begin
        // noise: any index including out-of-range ones, any contacts, any jump
        scan($urandom_range(127), 1'($urandom_range(1)), 1'($urandom_range(1)),
             $urandom_range(1) ? $urandom_range(50000) : $urandom());
      end
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (pending_scans.size() != 0 || in_valid || awaited_events.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    note_offset = 7'd21; on_fast = 20'd3000; on_slow = 20'd120000;
    off_fast = 20'd4000; off_slow = 20'd80000; bias = 16'd6554; settle_us = 20'd5000;
    for (int i = 0; i < NUM_KEYS; i++) begin
      key_pos[i] = POS_UP; travel_t0[i] = 0; upper_t[i] = 0; lower_t[i] = 0;
      upper_locked[i] = 0; lower_locked[i] = 0; upper_closed[i] = 0; lower_closed[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings, edge keys, fast and slow travel, bounce-back,
    // out-of-range indexes, timestamp wrap across a press.
    clock_us = 32'hFFFF_0000;
    keystroke(0, 1000, 500);
    keystroke(NUM_KEYS - 1, 200000, 200000);
    scan(NUM_KEYS, 1'b1, 1'b1, 10);
    scan(127, 1'b1, 1'b0, 10);
    scan(5, 1'b1, 1'b0, 10000);
    scan(5, 1'b0, 1'b0, 10000);  // upper opens before lower: back to key up
    scan(5, 1'b1, 1'b1, 10000);
    scan(5, 1'b1, 1'b1, 10000);
    scan(5, 1'b0, 1'b0, 60000);
    random_phase(10);
    wait_drained();

    // Extremes: top offset saturates notes, widest ranges, no lockout.
    write_all(7'd127, 20'd0, 20'hFFFFF, 20'd0, 20'hFFFFF, 16'hFFFF, 20'd0);
    clock_us = $urandom();
    random_phase(300);
    wait_drained();

    // Slowest not above fastest, zero bias, longest lockout.
    write_all(7'd0, 20'hFFFFF, 20'd1, 20'd50000, 20'd50000, 16'd0, 20'hFFFFF);
    clock_us = $urandom();
    random_phase(250);
    wait_drained();

    // Smallest nonzero bias, narrow ranges.
    write_all(7'd40, 20'd10000, 20'd10001, 20'd0, 20'd1, 16'd1, 20'd1);
    clock_us = $urandom();
    random_phase(250);
    wait_drained();

    // Random settings.
    for (int p = 0; p < 3; p++) begin
      write_all(7'($urandom_range(127)), 20'($urandom_range(40000)),
                20'($urandom_range(200000, 1)), 20'($urandom_range(40000)),
                20'($urandom_range(200000, 1)), 16'($urandom_range(65535, 1)),
                20'($urandom_range(20000)));
      clock_us = $urandom();
      random_phase(250);
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("dual_contact_key_velocity_top_test passed");
    end else begin
      $display("dual_contact_key_velocity_top_test failed");
    end
    $finish;
  end
endmodule
